/* rtl/triangle_edge_neighbor_finder_unit_defines.svh */
// Assertion macros used by the checker file.
`ifndef TRIANGLE_EDGE_NEIGHBOR_FINDER_UNIT_DEFINES_SVH
`define TRIANGLE_EDGE_NEIGHBOR_FINDER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, idle during reset.
`define TENF_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tenf checker: same-cycle property failed");

// Next-cycle implication, sampled on the rising clock, idle during reset.
`define TENF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tenf checker: next-cycle property failed");

`endif

/* rtl/tenf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tenf_pkg;

   // Field widths of the request and response transfers
   localparam int OP_W   = 1;
   localparam int TRI_W  = 12;
   localparam int NODE_W = 10;
   localparam int SIDE_W = 2;
   localparam int NBR_W  = 13;

   typedef logic [OP_W-1:0]          op_type;
   typedef logic [TRI_W-1:0]         tri_id_type;
   typedef logic [NODE_W-1:0]        node_id_type;
   typedef logic [SIDE_W-1:0]        side_type;
   typedef logic signed [NBR_W-1:0]  nbr_type;

   // Operation codes
   localparam op_type OP_ADD   = 1'b0;
   localparam op_type OP_QUERY = 1'b1;

   // Side codes
   localparam side_type SIDE_AB = 2'd0;
   localparam side_type SIDE_BC = 2'd1;
   localparam side_type SIDE_CA = 2'd2;

   // Neighbor value reported for a boundary side (-1)
   localparam nbr_type BOUNDARY = '1;

endpackage

`default_nettype wire

/* rtl/triangle_edge_neighbor_finder_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Add: count read in S_ADD_RD, then id and count write in S_ADD_WR, then req_ready returns.
// Query: per side, count reads (S_LEN0, S_LEN1, S_LEN1W), an end-of-list check (S_I_ISSUE)
//   and a response (S_EMIT), plus per entry of the first list a fetch (S_I_ISSUE, S_I_CAND)
//   and a second-list scan (S_J_SCAN). The worst case (16-entry lists) is set by the single read port
//   of the incidence RAM; the next request is taken only after the third response.
// Reset: a clearing pass zeroes every node count (req_ready low meanwhile); overflow clears.
module triangle_edge_neighbor_finder_unit #(
   parameter int NODES       = 1024,
   parameter int TRIANGLES   = 4096,
   parameter int MAX_VALENCE = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire tenf_pkg::op_type      req_operation,
   input  wire tenf_pkg::tri_id_type  req_triangle,
   input  wire tenf_pkg::node_id_type req_node_a,
   input  wire tenf_pkg::node_id_type req_node_b,
   input  wire tenf_pkg::node_id_type req_node_c,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output tenf_pkg::side_type         rsp_side,
   output tenf_pkg::nbr_type          rsp_neighbor,
   output logic                       rsp_overflow,
   output logic                       rsp_last
);

   import tenf_pkg::*;

   localparam int NODE_AW = $clog2(NODES);
   localparam int VAL_W   = $clog2(MAX_VALENCE);
   localparam int CNT_W   = $clog2(MAX_VALENCE + 1);
   localparam int ID_AW   = NODE_AW + VAL_W;
   localparam int ID_DEPTH = NODES * (2 ** VAL_W);

   // Sequencer states
   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_ADD_RD  = 4'd2;
   localparam logic [3:0] S_ADD_WR  = 4'd3;
   localparam logic [3:0] S_LEN0    = 4'd4;
   localparam logic [3:0] S_LEN1    = 4'd5;
   localparam logic [3:0] S_LEN1W   = 4'd6;
   localparam logic [3:0] S_I_ISSUE = 4'd7;
   localparam logic [3:0] S_I_CAND  = 4'd8;
   localparam logic [3:0] S_J_SCAN  = 4'd9;
   localparam logic [3:0] S_EMIT    = 4'd10;

   logic [3:0]         state_ff, state_in;
   logic [NODE_AW-1:0] clr_ff, clr_in;
   logic               ovf_ff, ovf_in;
   side_type           side_ff, side_in;
   tri_id_type         tri_ff, tri_in;
   node_id_type        na_ff, na_in;
   node_id_type        nb_ff, nb_in;
   node_id_type        nc_ff, nc_in;
   logic [2:0]         nval_ff, nval_in;
   logic [CNT_W-1:0]   len0_ff, len0_in;
   logic [CNT_W-1:0]   len1_ff, len1_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic               pend_ff, pend_in;
   tri_id_type         cand_ff, cand_in;
   nbr_type            nbr_ff, nbr_in;

   // RAM ports
   logic               cnt_we;
   logic [NODE_AW-1:0] cnt_wa, cnt_ra;
   logic [CNT_W-1:0]   cnt_wd, cnt_rd;
   logic               id_we;
   logic [ID_AW-1:0]   id_wa, id_ra;
   tri_id_type         id_rd;

   // Side endpoints
   node_id_type        n0, n1;
   logic               v0, v1;
   logic [NODE_AW-1:0] n0_addr, n1_addr, na_addr;
   logic               req_xfer;
   logic               cnt_full;
   logic               hit;

   assign req_xfer = req_valid && req_ready;
   assign na_addr  = NODE_AW'(na_ff);
   assign n0_addr  = NODE_AW'(n0);
   assign n1_addr  = NODE_AW'(n1);
   assign cnt_full = (cnt_rd >= CNT_W'(MAX_VALENCE));
   assign hit      = pend_ff && (id_rd == cand_ff);

   // Endpoint nodes of the current side
   always_comb begin
      unique case (side_ff)
         SIDE_AB: begin
            n0 = na_ff; n1 = nb_ff; v0 = nval_ff[0]; v1 = nval_ff[1];
         end
         SIDE_BC: begin
            n0 = nb_ff; n1 = nc_ff; v0 = nval_ff[1]; v1 = nval_ff[2];
         end
         SIDE_CA: begin
            n0 = nc_ff; n1 = na_ff; v0 = nval_ff[2]; v1 = nval_ff[0];
         end
         default: begin
            n0 = na_ff; n1 = nb_ff; v0 = nval_ff[0]; v1 = nval_ff[1];
         end
      endcase
   end

   // Count RAM access
   always_comb begin
      unique case (state_ff)
         S_ADD_RD: cnt_ra = na_addr;
         S_LEN1:   cnt_ra = n1_addr;
         default:  cnt_ra = n0_addr;
      endcase
      cnt_we = (state_ff == S_CLEAR) || ((state_ff == S_ADD_WR) && !cnt_full);
      cnt_wa = (state_ff == S_CLEAR) ? clr_ff : na_addr;
      cnt_wd = (state_ff == S_CLEAR) ? '0 : cnt_rd + CNT_W'(1);
   end

   // Incidence RAM access
   always_comb begin
      id_we = (state_ff == S_ADD_WR) && !cnt_full;
      id_wa = {na_addr, cnt_rd[VAL_W-1:0]};
      if (state_ff == S_J_SCAN) begin
         id_ra = {n1_addr, j_ff[VAL_W-1:0]};
      end else begin
         id_ra = {n0_addr, i_ff[VAL_W-1:0]};
      end
   end

   tenf_ram #(
      .WIDTH (CNT_W),
      .DEPTH (NODES)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_wa),
      .wr_data (cnt_wd),
      .rd_addr (cnt_ra),
      .rd_data (cnt_rd)
   );

   tenf_ram #(
      .WIDTH (TRI_W),
      .DEPTH (ID_DEPTH)
   ) u_id_ram (
      .clock   (clock),
      .wr_en   (id_we),
      .wr_addr (id_wa),
      .wr_data (tri_ff),
      .rd_addr (id_ra),
      .rd_data (id_rd)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      ovf_in   = ovf_ff;
      side_in  = side_ff;
      tri_in   = tri_ff;
      na_in    = na_ff;
      nb_in    = nb_ff;
      nc_in    = nc_ff;
      nval_in  = nval_ff;
      len0_in  = len0_ff;
      len1_in  = len1_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      pend_in  = pend_ff;
      cand_in  = cand_ff;
      nbr_in   = nbr_ff;

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + NODE_AW'(1);
            if (clr_ff == NODE_AW'(NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               tri_in  = req_triangle;
               na_in   = req_node_a;
               nb_in   = req_node_b;
               nc_in   = req_node_c;
               nval_in = {32'(req_node_c) < NODES, 32'(req_node_b) < NODES,
                          32'(req_node_a) < NODES};
               side_in = SIDE_AB;
               if (req_operation == OP_QUERY) begin
                  state_in = S_LEN0;
               end else if (32'(req_triangle) >= TRIANGLES) begin
                  state_in = S_IDLE;
               end else if (32'(req_node_a) >= NODES) begin
                  ovf_in = 1'b1;
               end else begin
                  state_in = S_ADD_RD;
               end
            end
         end
         S_ADD_RD: begin
            state_in = S_ADD_WR;
         end
         S_ADD_WR: begin
            // full list: drop the entry and flag it
            if (cnt_full) begin
               ovf_in = 1'b1;
            end
            state_in = S_IDLE;
         end
         S_LEN0: begin
            // out-of-range node: side is a boundary
            if (v0 && v1) begin
               state_in = S_LEN1;
            end else begin
               nbr_in   = BOUNDARY;
               state_in = S_EMIT;
            end
         end
         S_LEN1: begin
            len0_in  = cnt_rd;
            state_in = S_LEN1W;
         end
         S_LEN1W: begin
            len1_in  = cnt_rd;
            i_in     = '0;
            state_in = S_I_ISSUE;
         end
         S_I_ISSUE: begin
            if (i_ff < len0_ff) begin
               state_in = S_I_CAND;
            end else begin
               nbr_in   = BOUNDARY;
               state_in = S_EMIT;
            end
         end
         S_I_CAND: begin
            cand_in = id_rd;
            i_in    = i_ff + CNT_W'(1);
            // skip the queried triangle itself
            if (id_rd == tri_ff) begin
               state_in = S_I_ISSUE;
            end else begin
               j_in     = '0;
               pend_in  = 1'b0;
               state_in = S_J_SCAN;
            end
         end
         S_J_SCAN: begin
            // one read issued and one compare per cycle
            priority if (hit) begin
               nbr_in   = {1'b0, cand_ff};
               pend_in  = 1'b0;
               state_in = S_EMIT;
            end else if (j_ff < len1_ff) begin
               j_in    = j_ff + CNT_W'(1);
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = S_I_ISSUE;
            end
         end
         S_EMIT: begin
            if (rsp_ready) begin
               if (side_ff == SIDE_CA) begin
                  state_in = S_IDLE;
               end else begin
                  side_in  = side_ff + SIDE_W'(1);
                  state_in = S_LEN0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         ovf_ff   <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         ovf_ff   <= ovf_in;
         pend_ff  <= pend_in;
      end
   end

   // Payload and loop registers
   always_ff @(posedge clock) begin
      side_ff <= side_in;
      tri_ff  <= tri_in;
      na_ff   <= na_in;
      nb_ff   <= nb_in;
      nc_ff   <= nc_in;
      nval_ff <= nval_in;
      len0_ff <= len0_in;
      len1_ff <= len1_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      cand_ff <= cand_in;
      nbr_ff  <= nbr_in;
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = (state_ff == S_EMIT);
   assign rsp_side     = side_ff;
   assign rsp_neighbor = nbr_ff;
   assign rsp_overflow = ovf_ff;
   assign rsp_last     = (side_ff == SIDE_CA);

endmodule

`default_nettype wire

/* rtl/tenf_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read.
module tenf_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 1024
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]          wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic      [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/tenf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "triangle_edge_neighbor_finder_unit_defines.svh"

// Port-level checks on the finder
module tenf_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire tenf_pkg::op_type      req_operation,
   input wire tenf_pkg::tri_id_type  req_triangle,
   input wire tenf_pkg::node_id_type req_node_a,
   input wire tenf_pkg::node_id_type req_node_b,
   input wire tenf_pkg::node_id_type req_node_c,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire tenf_pkg::side_type    rsp_side,
   input wire tenf_pkg::nbr_type     rsp_neighbor,
   input wire logic                  rsp_overflow,
   input wire logic                  rsp_last
);

   import tenf_pkg::*;

   logic req_seen;

   // Request payload is sampled only to keep every port observed
   assign req_seen = req_valid && ^{req_operation, req_triangle, req_node_a,
                                    req_node_b, req_node_c};

   // A stalled response holds its payload
   `TENF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_side) && $stable(rsp_neighbor) && $stable(rsp_last))

   // Last marks the third side, and the side code is one of three
   `TENF_ASSERT_IMPL(a_last_side, rsp_valid, (rsp_last == (rsp_side == SIDE_CA)) && (rsp_side == SIDE_AB || rsp_side == SIDE_BC || rsp_side == SIDE_CA))

   // Neighbor is either a boundary or a non-negative triangle id
   `TENF_ASSERT_IMPL(a_nbr_form, rsp_valid, rsp_neighbor == BOUNDARY || !rsp_neighbor[NBR_W-1])

   // No new request is taken while a query is still answering
   `TENF_ASSERT_IMPL(a_one_item, req_ready || req_seen, !(req_ready && rsp_valid))

endmodule

bind triangle_edge_neighbor_finder_unit tenf_checker u_tenf_checker (.*);

`default_nettype wire
